// ===== hw/rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scan unit.
package wbps_pkg;

   localparam int MAX_PATTERN = 128;
   localparam int LEN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam logic [1:0] MATCH_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BEGIN = 2'd1,
      OP_SCAN  = 2'd2
   } op_type;

   typedef logic [MAX_PATTERN-1:0] vec_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  entry_index;
      logic [7:0]  pattern_byte;
      logic        wildcard_req;
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic        region_start;
      logic        image_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  match_count;
      logic [31:0] first_match_address;
      logic        first_match_valid;
      logic        match_here;
      logic        finished;
   } rsp_type;

   typedef struct packed {
      logic       we;
      logic [6:0] index;
      logic [7:0] value;
      logic       wild;
   } load_type;

endpackage

// ===== hw/rtl/wbps_channels.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface wbps_req_if import wbps_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wbps_rsp_if import wbps_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/wbps_match_array.sv =====
// Pattern entry storage and per-entry byte compare cells.
module wbps_match_array
   import wbps_pkg::*;
(
   input  logic     clock,
   input  load_type load,
   input  logic [7:0] data_byte,
   output vec_type  hit
);

   logic [7:0] pattern_ff [MAX_PATTERN];
   logic       wild_ff    [MAX_PATTERN];

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_entry
      logic sel;
      assign sel = load.we && ({25'd0, load.index} == 32'(i));

      always_ff @(posedge clock) begin
         if (sel) begin
            pattern_ff[i] <= load.value;
            wild_ff[i]    <= load.wild;
         end
      end

      assign hit[i] = wild_ff[i] || (pattern_ff[i] == data_byte);
   end

endmodule

// ===== hw/rtl/wbps_search_core.sv =====
// Shift-and partial match vector, match counter and length register.
module wbps_search_core
   import wbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       fire,
   input  req_type    req,
   input  vec_type    hit,
   output rsp_type    result
);

   logic [LEN_IDX_W-1:0] len_m1_ff, len_m1_in;
   vec_type              pm_ff, pm_in, pm_base, pm_next;
   logic [1:0]           count_ff, count_in;
   logic [31:0]          first_addr_ff, first_addr_in;
   logic                 first_seen_ff, first_seen_in;
   logic                 stopped_ff, stopped_in;
   logic                 here;

   always_comb begin
      if (csr_wdata == 8'd0) begin
         len_m1_in = '0;
      end else if ({24'd0, csr_wdata} > 32'(MAX_PATTERN)) begin
         len_m1_in = LEN_IDX_W'(MAX_PATTERN - 1);
      end else begin
         len_m1_in = LEN_IDX_W'(csr_wdata - 8'd1);
      end
   end

   always_comb begin
      pm_base    = req.region_start ? '0 : pm_ff;
      pm_next[0] = hit[0];
      for (int i = 1; i < MAX_PATTERN; i++) begin
         pm_next[i] = pm_base[i-1] & hit[i];
      end
   end

   always_comb begin
      pm_in         = pm_ff;
      count_in      = count_ff;
      first_addr_in = first_addr_ff;
      first_seen_in = first_seen_ff;
      stopped_in    = stopped_ff;
      here          = 1'b0;
      if (fire) begin
         unique case (op_type'(req.operation))
            OP_LOAD: begin
            end
            OP_BEGIN: begin
               pm_in         = '0;
               count_in      = '0;
               first_addr_in = '0;
               first_seen_in = 1'b0;
               stopped_in    = 1'b0;
            end
            OP_SCAN: begin
               if (!stopped_ff) begin
                  pm_in = pm_next;
                  if (pm_next[len_m1_ff]) begin
                     here = 1'b1;
                     if (!first_seen_ff) begin
                        first_seen_in = 1'b1;
                        first_addr_in = req.byte_address - 32'(len_m1_ff);
                     end
                     if (count_ff != MATCH_LIMIT) begin
                        count_in = count_ff + 2'd1;
                     end
                     if (count_in == MATCH_LIMIT) begin
                        stopped_in = 1'b1;
                     end
                  end
                  if (req.image_end) begin
                     stopped_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_m1_ff     <= '0;
         pm_ff         <= '0;
         count_ff      <= '0;
         first_addr_ff <= '0;
         first_seen_ff <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            len_m1_ff <= len_m1_in;
         end
         pm_ff         <= pm_in;
         count_ff      <= count_in;
         first_addr_ff <= first_addr_in;
         first_seen_ff <= first_seen_in;
         stopped_ff    <= stopped_in;
      end
   end

   assign result.match_count         = count_in;
   assign result.first_match_address = first_addr_in;
   assign result.first_match_valid   = first_seen_in;
   assign result.match_here          = here;
   assign result.finished            = stopped_in;

`ifndef NO_ASSERTIONS
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("match count beyond limit");

   a_count_first: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd0) |-> first_seen_ff)
      else $error("match counted without first address");

   a_limit_stop: assert property (@(posedge clock) disable iff (reset)
      (count_ff == MATCH_LIMIT) |-> stopped_ff)
      else $error("search not stopped at match limit");

   a_begin_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && req.operation == OP_BEGIN) |=>
         (pm_ff == '0 && count_ff == 2'd0 && !first_seen_ff && !stopped_ff))
      else $error("begin transaction did not clear search");

   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      (stopped_ff && !(fire && req.operation == OP_BEGIN)) |=>
         (stopped_ff && (pm_ff === $past(pm_ff)) && $stable(count_ff)))
      else $error("stopped search changed state");
`endif

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scan_unit.sv =====
// An accepted transaction passes from the input register to the response register, which drives
// valid. One transaction per cycle while the response side applies no back pressure.
// Back pressure stalls the input and response registers together; one transaction
// is still accepted while a response waits. Synchronous active-high reset clears
// control and search state; pattern entries stay undefined until loaded.
module wildcard_byte_pattern_scan_unit
   import wbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   wbps_req_if.sink   req_if,
   wbps_rsp_if.source rsp_if
);

   logic     s1_valid_ff;
   req_type  s1_req_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   logic     advance;
   logic     fire;
   load_type load;
   vec_type  hit;
   rsp_type  result;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_req_ff <= req_if.payload;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign load.we    = fire && (s1_req_ff.operation == OP_LOAD);
   assign load.index = s1_req_ff.entry_index;
   assign load.value = s1_req_ff.pattern_byte;
   assign load.wild  = s1_req_ff.wildcard_req;

   wbps_match_array u_array (
      .clock     (clock),
      .load      (load),
      .data_byte (s1_req_ff.data_byte),
      .hit       (hit)
   );

   wbps_search_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .req       (s1_req_ff),
      .hit       (hit),
      .result    (result)
   );

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

// ===== tb/sv/wbps_scan_checker.sv =====
// Checker for the wildcard byte pattern scan unit: tracks search state and compares responses.
module wbps_scan_checker
   import wbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   output int         pending,
   output int         fail_count
);

   localparam int PRINT_LIMIT = 20;

   logic [7:0]  pat_val [MAX_PATTERN];
   logic        pat_any [MAX_PATTERN];
   vec_type     partial;
   logic [1:0]  hits;
   logic [31:0] first_addr;
   logic        first_ok;
   logic        stopped;
   logic [7:0]  len_reg;
   rsp_type     scan_rsp_q[$];

   initial begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_val[i] = '0;
         pat_any[i] = 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic void clear_search();
      partial    = '0;
      hits       = '0;
      first_addr = '0;
      first_ok   = 1'b0;
      stopped    = 1'b0;
   endfunction

   function automatic logic entry_hit(input int i, input logic [7:0] b);
      return pat_any[i] || (pat_val[i] == b);
   endfunction

   // Advance the search by one transaction and return the response it yields.
   function automatic rsp_type scan_step(input req_type r);
      rsp_type o;
      int      n;
      int      i;
      logic    here;
      here = 1'b0;
      n = (len_reg == 0) ? 1 : (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
      case (r.operation)
         OP_LOAD: begin
            pat_val[r.entry_index] = r.pattern_byte;
            pat_any[r.entry_index] = r.wildcard_req;
         end
         OP_BEGIN: clear_search();
         OP_SCAN: begin
            if (!stopped) begin
               if (r.region_start)
                  partial = '0;
               for (i = MAX_PATTERN - 1; i > 0; i--)
                  partial[i] = partial[i-1] && entry_hit(i, r.data_byte);
               partial[0] = entry_hit(0, r.data_byte);
               if (partial[n-1]) begin
                  here = 1'b1;
                  if (!first_ok) begin
                     first_ok   = 1'b1;
                     first_addr = r.byte_address - 32'(n - 1);
                  end
                  if (hits < MATCH_LIMIT)
                     hits++;
                  if (hits >= MATCH_LIMIT)
                     stopped = 1'b1;
               end
               if (r.image_end)
                  stopped = 1'b1;
            end
         end
         default: ;
      endcase
      o.match_count         = hits;
      o.first_match_address = first_addr;
      o.first_match_valid   = first_ok;
      o.match_here          = here;
      o.finished            = stopped;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         clear_search();
         len_reg = 8'd1;
         scan_rsp_q.delete();
      end else begin
         if (csr_we)
            len_reg = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (scan_rsp_q.size() == 0) begin
               report_mismatch("response with none outstanding", 32'(rsp_data), '0);
            end else begin
               e = scan_rsp_q.pop_front();
               if (rsp_data.match_count !== e.match_count)
                  report_mismatch("match_count", 32'(rsp_data.match_count),
                                  32'(e.match_count));
               if (rsp_data.first_match_address !== e.first_match_address)
                  report_mismatch("first_match_address", rsp_data.first_match_address,
                                  e.first_match_address);
               if (rsp_data.first_match_valid !== e.first_match_valid)
                  report_mismatch("first_match_valid", 32'(rsp_data.first_match_valid),
                                  32'(e.first_match_valid));
               if (rsp_data.match_here !== e.match_here)
                  report_mismatch("match_here", 32'(rsp_data.match_here),
                                  32'(e.match_here));
               if (rsp_data.finished !== e.finished)
                  report_mismatch("finished", 32'(rsp_data.finished), 32'(e.finished));
            end
         end
         if (req_valid && req_ready)
            scan_rsp_q.push_back(scan_step(req_data));
      end
      pending = scan_rsp_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top-level testbench for the wildcard byte pattern scan unit: stimulus, watchdog and verdict.
module tb;
   import wbps_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int IDLE_PCT    = 34;
   localparam int CALM_FROM   = 350;
   localparam int CALM_TO     = 500;
   localparam int HOLD_AT     = 250;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 1000;
   localparam int ITEM_TARGET = 720;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   int         items_sent = 0;
   int         pending;
   int         fail_count;

   logic [7:0] pat_byte [MAX_PATTERN];
   logic       pat_wild [MAX_PATTERN];
   logic       loaded   [MAX_PATTERN];

   wbps_req_if req_if ();
   wbps_rsp_if rsp_if ();

   wildcard_byte_pattern_scan_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   wbps_scan_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.payload),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.payload),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #5 clock = ~clock;

   function automatic bit calm();
      return items_sent >= CALM_FROM && items_sent < CALM_TO;
   endfunction

   function automatic req_type rand_req();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[59:0];
   endfunction

   function automatic logic [7:0] any_byte(input int eff);
      if ($urandom_range(4) < 2)
         return 8'($urandom);
      return pat_byte[$urandom_range(eff - 1)];
   endfunction

   task automatic send(input req_type r);
      while (!calm() && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_op(input logic [1:0] op);
      req_type r;
      r = rand_req();
      r.operation = op;
      send(r);
   endtask

   task automatic load_entry(input logic [6:0] idx, input logic [7:0] b, input logic w);
      req_type r;
      r = rand_req();
      r.operation    = OP_LOAD;
      r.entry_index  = idx;
      r.pattern_byte = b;
      r.wildcard_req = w;
      pat_byte[idx]  = b;
      pat_wild[idx]  = w;
      loaded[idx]    = 1'b1;
      send(r);
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic [31:0] a, input logic rs,
                            input logic ie);
      req_type r;
      r = rand_req();
      r.operation    = OP_SCAN;
      r.data_byte    = b;
      r.byte_address = a;
      r.region_start = rs;
      r.image_end    = ie;
      send(r);
   endtask

   // Register writes only once every response is back.
   task automatic set_length(input logic [7:0] v);
      req_if.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_search(input int eff, input int events);
      logic [31:0] a;
      logic [7:0]  b;
      int          k;
      int          n;
      int          j;
      int          sel;
      logic        brk;
      send_op(OP_BEGIN);
      case ($urandom_range(4))
         0: a = 32'hFFFF_FFFF - $urandom_range(eff + 2);
         1: a = $urandom_range(3);
         default: a = $urandom;
      endcase
      for (k = 0; k < events; k++) begin
         sel = (k == 0) ? 0 : $urandom_range(9);
         if (sel < 6) begin
            j   = ($urandom_range(4) == 0) ? $urandom_range(eff - 1) : -1;
            brk = 1'($urandom_range(1));
            for (n = 0; n < eff; n++) begin
               b = pat_wild[n] ? 8'($urandom) : pat_byte[n];
               if (n == j && !brk)
                  b = ~b;
               scan_byte(b, a, (n == j && brk) || (n == 0 && $urandom_range(4) == 0), 1'b0);
               a++;
            end
         end else if (sel < 9) begin
            repeat ($urandom_range(1, 4)) begin
               scan_byte(any_byte(eff), a, $urandom_range(11) == 0, $urandom_range(99) == 0);
               a++;
            end
         end else if ($urandom_range(1)) begin
            load_entry(7'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            send_op(OP_SPARE);
         end
      end
      if ($urandom_range(1)) begin
         scan_byte(any_byte(eff), a, 1'b0, 1'b1);
         a++;
      end
      repeat ($urandom_range(2)) begin
         scan_byte(any_byte(eff), a, 1'b0, 1'b0);
         a++;
      end
   endtask

   task automatic run_phase(input logic [7:0] len, input int searches, input int events);
      int eff;
      int n;
      eff = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
      set_length(len);
      for (n = 0; n < eff; n++)
         if (!loaded[n] || n < 8)
            load_entry(7'(n), $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(3)),
                       $urandom_range(99) < 25);
      repeat (searches) run_search(eff, events);
   endtask

   // Response side: random back pressure plus one long hold-off.
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && items_sent >= HOLD_AT) begin
            held = 1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm() || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      logic [7:0] len;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_byte[i] = '0;
         pat_wild[i] = 1'b0;
         loaded[i]   = 1'b0;
      end
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: length 3, pattern 00 ?? FF.
      set_length(8'd3);
      load_entry(7'd0, 8'h00, 1'b0);
      load_entry(7'd1, 8'hFF, 1'b1);
      load_entry(7'd2, 8'hFF, 1'b0);
      load_entry(7'd127, 8'hAA, 1'b1);
      send_op(OP_SPARE);
      send_op(OP_BEGIN);
      scan_byte(8'h00, 32'd0, 1'b1, 1'b0);
      scan_byte(8'h55, 32'd1, 1'b0, 1'b0);
      scan_byte(8'hFF, 32'd2, 1'b0, 1'b0);
      scan_byte(8'h00, 32'd10, 1'b0, 1'b0);
      scan_byte(8'h33, 32'd11, 1'b0, 1'b0);
      scan_byte(8'hFF, 32'd12, 1'b1, 1'b0);
      load_entry(7'd1, 8'h77, 1'b1);
      scan_byte(8'h00, 32'd20, 1'b0, 1'b0);
      scan_byte(8'h12, 32'd21, 1'b0, 1'b0);
      scan_byte(8'hFF, 32'd22, 1'b0, 1'b0);
      scan_byte(8'h00, 32'd23, 1'b0, 1'b0);
      send_op(OP_BEGIN);
      scan_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
      scan_byte(8'hAB, 32'd0, 1'b0, 1'b0);
      scan_byte(8'hFF, 32'd1, 1'b0, 1'b1);
      scan_byte(8'h00, 32'd2, 1'b0, 1'b0);
      send_op(OP_BEGIN);
      scan_byte(8'h00, 32'd7, 1'b0, 1'b1);

      run_phase(8'd255, 1, 1);
      run_phase(8'd128, 1, 1);
      run_phase(8'd0, 2, 6);
      run_phase(8'd1, 2, 6);
      while (items_sent < ITEM_TARGET) begin
         len = ($urandom_range(4) == 0) ? 8'($urandom_range(7, 24)) : 8'($urandom_range(1, 6));
         run_phase(len, $urandom_range(1, 3), $urandom_range(2, 6));
      end

      req_if.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_channels.sv
hw/rtl/wbps_match_array.sv
hw/rtl/wbps_search_core.sv
hw/rtl/wildcard_byte_pattern_scan_unit.sv
tb/sv/wbps_scan_checker.sv
tb/sv/tb.sv
